// File: design/isq_pkg.sv
package isq_pkg;

  // Stored value width
  localparam int DATA_W = 32;

  // Default number of elements held
  localparam int CAPACITY_DEFAULT = 64;

  // Request codes
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

// File: design/isq_ram.sv
module isq_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/indexed_sequence_store.sv
// Ordered sequence of up to CAPACITY signed 32-bit values, addressed by
// position (0 is the front). Each input beat on the item channel carries
// op (read, insert, delete), position and value; each produces exactly one
// beat on the result channel with read_value, status and the element count
// after the request. A bad request reports its status and changes nothing.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low.
// Steps: a read passes from S_RDATA to S_DONE, a rejected request or an
// unused op goes straight to S_DONE. An insert writes its value in S_PUT,
// first shifting the elements from p upward in S_INS if position p is below
// the end; a delete at p shifts any elements above p down in S_DEL. The shift
// moves one element per cycle through the single write port of the element
// memory, with one item in flight at a time.
// The result sits in an output register: the next item is accepted while a
// finished result still waits, and a stalled receiver only holds that item
// in its final step until the register frees up.
// Reset (synchronous, active high) empties the sequence at once; the memory
// contents are not cleared, as only written entries are ever read.
module indexed_sequence_store #(
  parameter int CAPACITY = isq_pkg::CAPACITY_DEFAULT,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [1:0]                 op,
  input  logic [CW-1:0]              position,
  input  logic [isq_pkg::DATA_W-1:0] value,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [isq_pkg::DATA_W-1:0] read_value,
  output logic [1:0]                 status,
  output logic [CW-1:0]              count
);

  import isq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int XW = CW + 1;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDATA = 3'd1;
  localparam logic [2:0] S_INS   = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_DEL   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state;
  logic [CW-1:0]     element_count;
  logic [CW-1:0]     pos_r;
  logic [DATA_W-1:0] val_r;
  logic [CW-1:0]     wr_addr;
  logic [DATA_W-1:0] res_value;
  logic [1:0]        res_status;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  logic              accept;
  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     cnt_x;
  logic [XW-1:0]     posr_x;
  logic [XW-1:0]     wr_x;
  logic              pos_lt_cnt;
  logic              pos_gt_cnt;
  logic              pos1_lt_cnt;
  logic              ins_more;
  logic              del_more;
  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     pos_p1;
  logic [CW-1:0]     wr_m2;
  logic [CW-1:0]     wr_p2;
  logic              out_free;

  assign accept     = item_valid && (state == S_IDLE);
  assign item_stall = (state != S_IDLE);
  assign out_free   = !result_valid || !result_stall;

  // Widen positions so the bound checks cannot wrap
  assign pos_x       = {1'b0, position};
  assign cnt_x       = {1'b0, element_count};
  assign posr_x      = {1'b0, pos_r};
  assign wr_x        = {1'b0, wr_addr};
  assign pos_lt_cnt  = (pos_x < cnt_x);
  assign pos_gt_cnt  = (pos_x > cnt_x);
  assign pos1_lt_cnt = ((pos_x + XW'(1)) < cnt_x);
  assign ins_more    = (wr_x > (posr_x + XW'(1)));
  assign del_more    = ((wr_x + XW'(1)) < cnt_x);

  assign cnt_m1 = element_count - CW'(1);
  assign pos_p1 = position + CW'(1);
  assign wr_m2  = wr_addr - CW'(2);
  assign wr_p2  = wr_addr + CW'(2);

  // Drive the memory ports: one read ahead of each shift write
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr[AW-1:0];
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = position[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_READ && pos_lt_cnt) begin
            mem_re    = 1'b1;
            mem_raddr = position[AW-1:0];
          end else if (op == OP_INSERT && pos_lt_cnt && element_count != CAP_CNT) begin
            mem_re    = 1'b1;
            mem_raddr = cnt_m1[AW-1:0];
          end else if (op == OP_DELETE && pos1_lt_cnt) begin
            mem_re    = 1'b1;
            mem_raddr = pos_p1[AW-1:0];
          end
        end
      end
      S_INS: begin
        mem_we = 1'b1;
        if (ins_more) begin
          mem_re    = 1'b1;
          mem_raddr = wr_m2[AW-1:0];
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[AW-1:0];
        mem_wdata = val_r;
      end
      S_DEL: begin
        mem_we = 1'b1;
        if (del_more) begin
          mem_re    = 1'b1;
          mem_raddr = wr_p2[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Sequence the request and update the element count
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      element_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pos_r     <= position;
            val_r     <= value;
            res_value <= '0;
            unique case (op)
              OP_READ: begin
                if (pos_lt_cnt) begin
                  res_status <= ST_OK;
                  state      <= S_RDATA;
                end else begin
                  res_status <= ST_RANGE;
                  state      <= S_DONE;
                end
              end
              OP_INSERT: begin
                if (pos_gt_cnt) begin
                  res_status <= ST_RANGE;
                  state      <= S_DONE;
                end else if (element_count == CAP_CNT) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  res_status    <= ST_OK;
                  element_count <= element_count + CW'(1);
                  wr_addr       <= element_count;
                  state         <= pos_lt_cnt ? S_INS : S_PUT;
                end
              end
              OP_DELETE: begin
                if (!pos_lt_cnt) begin
                  res_status <= ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  res_status    <= ST_OK;
                  element_count <= cnt_m1;
                  wr_addr       <= position;
                  state         <= pos1_lt_cnt ? S_DEL : S_DONE;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_RDATA: begin
          res_value <= mem_rdata;
          state     <= S_DONE;
        end
        S_INS: begin
          if (ins_more) begin
            wr_addr <= wr_addr - CW'(1);
          end else begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          state <= S_DONE;
        end
        S_DEL: begin
          if (del_more) begin
            wr_addr <= wr_addr + CW'(1);
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the result beat until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      read_value <= res_value;
      status     <= res_status;
      count      <= element_count;
    end
  end

  isq_ram #(
    .DEPTH(CAPACITY),
    .AW   (AW),
    .DW   (DATA_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule
